// File: rtl/ihv_pkg.sv
// Shared types and constants for the IPv4 header validator.
package ihv_pkg;

    localparam int IHV_QUEUE_DEPTH = 4;

    localparam logic [15:0] FLAG_DF     = 16'h4000;
    localparam logic [15:0] FLAG_MF     = 16'h2000;
    localparam logic [15:0] OFFSET_MASK = 16'h1fff;
    localparam logic [15:0] MIN_HEADER  = 16'd20;
    localparam logic [15:0] COUNT_MAX   = 16'hffff;
    localparam logic [15:0] SUM_GOOD    = 16'hffff;
    localparam logic [3:0]  IP_VERSION  = 4'd4;

    typedef enum logic [3:0] {
        VERDICT_OK        = 4'd0,
        VERDICT_DISABLED  = 4'd1,
        VERDICT_SHORT     = 4'd2,
        VERDICT_VERSION   = 4'd3,
        VERDICT_HDRLEN    = 4'd4,
        VERDICT_CHECKSUM  = 4'd5,
        VERDICT_TOTLEN    = 4'd6,
        VERDICT_TRUNCATED = 4'd7,
        VERDICT_TTL       = 4'd8
    } verdict_t;

    // Everything the checker needs about one finished packet.
    typedef struct packed {
        logic        enabled;
        logic [15:0] byte_count;
        logic [15:0] checksum;
        logic [7:0]  version_ihl;
        logic [15:0] length_field;
        logic [15:0] ident_field;
        logic [15:0] flags_offset;
        logic [7:0]  ttl_field;
        logic [7:0]  proto_field;
        logic [31:0] src_field;
        logic [31:0] dst_field;
    } pkt_rec_t;

endpackage

// File: rtl/ihv_fifo.sv
// Small register queue carrying packet records from the byte parser to the checker.
module ihv_fifo
    import ihv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = IHV_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_TOP = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == COUNT_TOP);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ihv_front.sv
// Byte parser: counts bytes, latches header fields and runs the header checksum.
module ihv_front
    import ihv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic [7:0] s_data_byte,
    input  logic     s_last_byte,
    input  logic     enabled,
    output logic     rec_push,
    output pkt_rec_t rec_data,
    input  logic     rec_full
);
    logic [15:0] count_reg,  count_next;
    logic [15:0] sum_reg,    sum_next;
    logic [7:0]  hold_reg,   hold_next;
    logic [7:0]  vihl_reg,   vihl_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] ident_reg,  ident_next;
    logic [15:0] flags_reg,  flags_next;
    logic [7:0]  ttl_reg,    ttl_next;
    logic [7:0]  proto_reg,  proto_next;
    logic [31:0] src_reg,    src_next;
    logic [31:0] dst_reg,    dst_next;

    logic        accepted;
    logic [15:0] pos;
    logic [5:0]  hlen_cur;
    logic [16:0] sum_wide;

    assign s_ready  = !rec_full;
    assign accepted = s_valid && s_ready;
    assign rec_push = accepted && s_last_byte;
    assign pos      = count_reg;

    // header length follows byte 0 as soon as it lands
    assign hlen_cur = (pos == 16'd0) ? {s_data_byte[3:0], 2'b00} : {vihl_reg[3:0], 2'b00};

    always_comb begin
        vihl_next  = vihl_reg;
        len_next   = len_reg;
        ident_next = ident_reg;
        flags_next = flags_reg;
        ttl_next   = ttl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        hold_next  = hold_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        sum_wide   = {1'b0, sum_reg} + {1'b0, hold_reg, s_data_byte};
        if (accepted) begin
            case (pos)
                16'd0:   vihl_next         = s_data_byte;
                16'd2:   len_next[15:8]    = s_data_byte;
                16'd3:   len_next[7:0]     = s_data_byte;
                16'd4:   ident_next[15:8]  = s_data_byte;
                16'd5:   ident_next[7:0]   = s_data_byte;
                16'd6:   flags_next[15:8]  = s_data_byte;
                16'd7:   flags_next[7:0]   = s_data_byte;
                16'd8:   ttl_next          = s_data_byte;
                16'd9:   proto_next        = s_data_byte;
                default: begin
                    if (pos >= 16'd12 && pos < 16'd16) begin
                        src_next = {src_reg[23:0], s_data_byte};
                    end else if (pos >= 16'd16 && pos < 16'd20) begin
                        dst_next = {dst_reg[23:0], s_data_byte};
                    end
                end
            endcase
            if ({10'd0, hlen_cur} > pos) begin
                if (!pos[0]) begin
                    hold_next = s_data_byte;
                end else begin
                    // end-around carry
                    sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
                end
            end
            if (pos != COUNT_MAX) begin
                count_next = pos + 16'd1;
            end
        end
    end

    always_comb begin
        rec_data.enabled      = enabled;
        rec_data.byte_count   = count_next;
        rec_data.checksum     = sum_next;
        rec_data.version_ihl  = vihl_next;
        rec_data.length_field = len_next;
        rec_data.ident_field  = ident_next;
        rec_data.flags_offset = flags_next;
        rec_data.ttl_field    = ttl_next;
        rec_data.proto_field  = proto_next;
        rec_data.src_field    = src_next;
        rec_data.dst_field    = dst_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || rec_push) begin
            count_reg <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            vihl_reg  <= '0;
            len_reg   <= '0;
            ident_reg <= '0;
            flags_reg <= '0;
            ttl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            hold_reg  <= hold_next;
            vihl_reg  <= vihl_next;
            len_reg   <= len_next;
            ident_reg <= ident_next;
            flags_reg <= flags_next;
            ttl_reg   <= ttl_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

endmodule

// File: rtl/ihv_back.sv
// Checker: turns one packet record into a verdict and holds it in the output register.
module ihv_back
    import ihv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pkt_rec_t    rec_data,
    input  logic        rec_empty,
    output logic        rec_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_verdict,
    output logic [5:0]  m_header_bytes,
    output logic [15:0] m_total_length,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_ident,
    output logic [7:0]  m_proto_number,
    output logic [31:0] m_source_address,
    output logic [31:0] m_dest_address,
    output logic [7:0]  m_hop_limit,
    output logic        m_is_fragment,
    output logic        m_more_fragments,
    output logic [15:0] m_fragment_byte_offset
);
    logic        valid_reg;
    verdict_t    verdict_reg, verdict_next;
    logic [5:0]  hlen_reg;
    logic [15:0] total_reg;
    logic [15:0] payload_reg, payload_next;
    logic [15:0] ident_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [7:0]  ttl_reg;
    logic        frag_reg, frag_next;
    logic        mf_reg, mf_next;
    logic [15:0] offset_reg, offset_next;

    logic [5:0]  hlen;
    logic [15:0] hlen_wide;

    assign rec_pop   = !rec_empty && (!valid_reg || m_ready);
    assign hlen      = {rec_data.version_ihl[3:0], 2'b00};
    assign hlen_wide = {10'd0, hlen};

    always_comb begin
        if (!rec_data.enabled) begin
            verdict_next = VERDICT_DISABLED;
        end else if (rec_data.byte_count < MIN_HEADER) begin
            verdict_next = VERDICT_SHORT;
        end else if (rec_data.version_ihl[7:4] != IP_VERSION) begin
            verdict_next = VERDICT_VERSION;
        end else if (hlen_wide < MIN_HEADER || hlen_wide > rec_data.byte_count) begin
            verdict_next = VERDICT_HDRLEN;
        end else if (rec_data.checksum != SUM_GOOD) begin
            verdict_next = VERDICT_CHECKSUM;
        end else if (rec_data.length_field < hlen_wide) begin
            verdict_next = VERDICT_TOTLEN;
        end else if (rec_data.byte_count < rec_data.length_field) begin
            verdict_next = VERDICT_TRUNCATED;
        end else if (rec_data.ttl_field == 8'd0) begin
            verdict_next = VERDICT_TTL;
        end else begin
            verdict_next = VERDICT_OK;
        end
    end

    // fragment facts only reported for accepted packets
    always_comb begin
        payload_next = '0;
        mf_next      = 1'b0;
        offset_next  = '0;
        frag_next    = 1'b0;
        if (verdict_next == VERDICT_OK) begin
            payload_next = rec_data.length_field - hlen_wide;
            mf_next      = (rec_data.flags_offset & FLAG_MF) != '0;
            offset_next  = {rec_data.flags_offset[12:0], 3'b000};
            frag_next    = mf_next || (offset_next != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            verdict_reg <= verdict_next;
            hlen_reg    <= hlen;
            total_reg   <= rec_data.length_field;
            payload_reg <= payload_next;
            ident_reg   <= rec_data.ident_field;
            proto_reg   <= rec_data.proto_field;
            src_reg     <= rec_data.src_field;
            dst_reg     <= rec_data.dst_field;
            ttl_reg     <= rec_data.ttl_field;
            frag_reg    <= frag_next;
            mf_reg      <= mf_next;
            offset_reg  <= offset_next;
        end
    end

    assign m_valid                = valid_reg;
    assign m_verdict              = verdict_reg;
    assign m_header_bytes         = hlen_reg;
    assign m_total_length         = total_reg;
    assign m_payload_length       = payload_reg;
    assign m_ident                = ident_reg;
    assign m_proto_number         = proto_reg;
    assign m_source_address       = src_reg;
    assign m_dest_address         = dst_reg;
    assign m_hop_limit            = ttl_reg;
    assign m_is_fragment          = frag_reg;
    assign m_more_fragments       = mf_reg;
    assign m_fragment_byte_offset = offset_reg;

endmodule

// File: rtl/ipv4_header_validator.sv
// IPv4 header validator: takes a packet one byte a word, gives one verdict word per packet.
// The block takes one packet byte per cycle while s_ready is high, with no gaps of its own.
// After the last byte is taken, the packet record passes through the queue between the byte
// parser and the checker, then into the checker's output register that drives the verdict
// word. The queue holds up to QUEUE_DEPTH finished packets while the result side is stalled.
// s_ready drops only when that queue is full. The enable register is written through the
// cfg channel, which is always ready, and should be changed only between packets.
module ipv4_header_validator
    import ihv_pkg::*;
#(
    parameter int QUEUE_DEPTH = IHV_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_input_enabled,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_verdict,
    output logic [5:0]  m_header_bytes,
    output logic [15:0] m_total_length,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_ident,
    output logic [7:0]  m_proto_number,
    output logic [31:0] m_source_address,
    output logic [31:0] m_dest_address,
    output logic [7:0]  m_hop_limit,
    output logic        m_is_fragment,
    output logic        m_more_fragments,
    output logic [15:0] m_fragment_byte_offset
);
    logic     enabled_reg;
    logic     rec_push, rec_full, rec_pop, rec_empty;
    pkt_rec_t push_rec, pop_rec;
    logic [$bits(pkt_rec_t)-1:0] pop_bits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b1;
        end else if (cfg_valid) begin
            enabled_reg <= cfg_input_enabled;
        end
    end

    ihv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .enabled     (enabled_reg),
        .rec_push    (rec_push),
        .rec_data    (push_rec),
        .rec_full    (rec_full)
    );

    ihv_fifo #(
        .WIDTH ($bits(pkt_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (rec_full),
        .pop       (rec_pop),
        .pop_data  (pop_bits),
        .empty     (rec_empty)
    );

    assign pop_rec = pkt_rec_t'(pop_bits);

    ihv_back u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .rec_data               (pop_rec),
        .rec_empty              (rec_empty),
        .rec_pop                (rec_pop),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_verdict              (m_verdict),
        .m_header_bytes         (m_header_bytes),
        .m_total_length         (m_total_length),
        .m_payload_length       (m_payload_length),
        .m_ident                (m_ident),
        .m_proto_number         (m_proto_number),
        .m_source_address       (m_source_address),
        .m_dest_address         (m_dest_address),
        .m_hop_limit            (m_hop_limit),
        .m_is_fragment          (m_is_fragment),
        .m_more_fragments       (m_more_fragments),
        .m_fragment_byte_offset (m_fragment_byte_offset)
    );

endmodule

// File: sim/ipv4_header_validator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 header validator: packet bytes in, verdict words out.
module ipv4_header_validator_test
    import ihv_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_BYTES   = 300;
    localparam int RANDOM_PACKETS = 10;
    localparam int PHASES         = 5;

    typedef struct {
        verdict_t    verdict;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [15:0] payload_length;
        logic [15:0] ident;
        logic [7:0]  proto_number;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  hop_limit;
        logic        is_fragment;
        logic        more_fragments;
        logic [15:0] fragment_byte_offset;
    } ip_verdict_t;

    // How to build one packet; cut > 0 keeps only that many leading bytes.
    typedef struct {
        logic [3:0]  version;
        logic [3:0]  ihl;
        bit          auto_len;
        logic [15:0] tot_len;
        logic [15:0] ident;
        logic [15:0] flags_off;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        int          payload;
        int          extra;
        int          cut;
        bit          bad_cks;
    } pkt_spec_t;

    class ipv4_verdict_scoreboard;
        bit          enabled;
        logic [15:0] byte_count;
        logic [15:0] hdr_sum;
        logic [7:0]  high_hold;
        logic [7:0]  ver_ihl;
        logic [15:0] length_fld;
        logic [15:0] ident_fld;
        logic [15:0] frag_fld;
        logic [7:0]  ttl_fld;
        logic [7:0]  proto_fld;
        logic [31:0] src_fld;
        logic [31:0] dst_fld;
        ip_verdict_t verdicts_due[$];
        int          errors;
        int          checked;
        int          verdict_tally[9];

        function new();
            enabled = 1'b1;
            errors  = 0;
            checked = 0;
            foreach (verdict_tally[i]) verdict_tally[i] = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count = '0;
            hdr_sum    = '0;
            high_hold  = '0;
            ver_ihl    = '0;
            length_fld = '0;
            ident_fld  = '0;
            frag_fld   = '0;
            ttl_fld    = '0;
            proto_fld  = '0;
            src_fld    = '0;
            dst_fld    = '0;
        endfunction

        function void set_enable(logic value);
            enabled = value;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void absorb_byte(logic [7:0] b, logic last);
            logic [5:0]  hlen;
            logic [16:0] acc;
            logic [15:0] pkt_len;
            ip_verdict_t r;
            case (byte_count)
                0:  ver_ihl = b;
                2:  length_fld[15:8] = b;
                3:  length_fld[7:0] = b;
                4:  ident_fld[15:8] = b;
                5:  ident_fld[7:0] = b;
                6:  frag_fld[15:8] = b;
                7:  frag_fld[7:0] = b;
                8:  ttl_fld = b;
                9:  proto_fld = b;
                12, 13, 14, 15: src_fld = {src_fld[23:0], b};
                16, 17, 18, 19: dst_fld = {dst_fld[23:0], b};
                default: ;
            endcase
            // header length follows byte 0 as soon as it lands
            hlen = {ver_ihl[3:0], 2'b00};
            if (byte_count < hlen) begin
                if (!byte_count[0]) begin
                    high_hold = b;
                end else begin
                    acc = hdr_sum + {high_hold, b};
                    hdr_sum = acc[15:0] + acc[16];
                end
            end
            if (byte_count != COUNT_MAX) byte_count++;
            if (!last) return;

            pkt_len = byte_count;
            r.payload_length       = '0;
            r.is_fragment          = 1'b0;
            r.more_fragments       = 1'b0;
            r.fragment_byte_offset = '0;
            if (!enabled) r.verdict = VERDICT_DISABLED;
            else if (pkt_len < MIN_HEADER) r.verdict = VERDICT_SHORT;
            else if (ver_ihl[7:4] != IP_VERSION) r.verdict = VERDICT_VERSION;
            else if (hlen < MIN_HEADER || hlen > pkt_len) r.verdict = VERDICT_HDRLEN;
            else if (hdr_sum != SUM_GOOD) r.verdict = VERDICT_CHECKSUM;
            else if (length_fld < hlen) r.verdict = VERDICT_TOTLEN;
            else if (pkt_len < length_fld) r.verdict = VERDICT_TRUNCATED;
            else if (ttl_fld == '0) r.verdict = VERDICT_TTL;
            else r.verdict = VERDICT_OK;
            if (r.verdict == VERDICT_OK) begin
                r.payload_length       = length_fld - hlen;
                r.more_fragments       = (frag_fld & FLAG_MF) != '0;
                r.fragment_byte_offset = (frag_fld & OFFSET_MASK) << 3;
                r.is_fragment = r.more_fragments || (r.fragment_byte_offset != '0);
            end
            r.header_bytes   = hlen;
            r.total_length   = length_fld;
            r.ident          = ident_fld;
            r.proto_number   = proto_fld;
            r.source_address = src_fld;
            r.dest_address   = dst_fld;
            r.hop_limit      = ttl_fld;
            verdicts_due.push_back(r);
            verdict_tally[int'(r.verdict)]++;
            clear_packet();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: verdict word %0d, %s expected 0x%0h got 0x%0h",
                         $time, checked, field, want, got);
                errors++;
            end
        endfunction

        function void check_verdict(ip_verdict_t got);
            ip_verdict_t want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict word with no packet pending, verdict 0x%0h",
                         $time, got.verdict);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("header_bytes", want.header_bytes, got.header_bytes);
            compare_field("total_length", want.total_length, got.total_length);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("ident", want.ident, got.ident);
            compare_field("proto_number", want.proto_number, got.proto_number);
            compare_field("source_address", want.source_address, got.source_address);
            compare_field("dest_address", want.dest_address, got.dest_address);
            compare_field("hop_limit", want.hop_limit, got.hop_limit);
            compare_field("is_fragment", want.is_fragment, got.is_fragment);
            compare_field("more_fragments", want.more_fragments, got.more_fragments);
            compare_field("fragment_byte_offset", want.fragment_byte_offset,
                          got.fragment_byte_offset);
            checked++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_input_enabled;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_verdict;
    logic [5:0]  m_header_bytes;
    logic [15:0] m_total_length;
    logic [15:0] m_payload_length;
    logic [15:0] m_ident;
    logic [7:0]  m_proto_number;
    logic [31:0] m_source_address;
    logic [31:0] m_dest_address;
    logic [7:0]  m_hop_limit;
    logic        m_is_fragment;
    logic        m_more_fragments;
    logic [15:0] m_fragment_byte_offset;

    ipv4_verdict_scoreboard sb = new();
    logic [7:0]  pkt_bytes[$];
    ip_verdict_t seen;
    bit          no_idle = 1'b0;
    bit          calm_phase = 1'b0;
    int          result_hold = 0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;
    int          packets_sent = 0;

    ipv4_header_validator i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_input_enabled      (cfg_input_enabled),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_data_byte            (s_data_byte),
        .s_last_byte            (s_last_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_verdict              (m_verdict),
        .m_header_bytes         (m_header_bytes),
        .m_total_length         (m_total_length),
        .m_payload_length       (m_payload_length),
        .m_ident                (m_ident),
        .m_proto_number         (m_proto_number),
        .m_source_address       (m_source_address),
        .m_dest_address         (m_dest_address),
        .m_hop_limit            (m_hop_limit),
        .m_is_fragment          (m_is_fragment),
        .m_more_fragments       (m_more_fragments),
        .m_fragment_byte_offset (m_fragment_byte_offset)
    );

    always #6 aclk = ~aclk;

    // result side: sample at the rising edge, stall for a random count after each word unless no_idle is set
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.verdict              = verdict_t'(m_verdict);
            seen.header_bytes         = m_header_bytes;
            seen.total_length         = m_total_length;
            seen.payload_length       = m_payload_length;
            seen.ident                = m_ident;
            seen.proto_number         = m_proto_number;
            seen.source_address       = m_source_address;
            seen.dest_address         = m_dest_address;
            seen.hop_limit            = m_hop_limit;
            seen.is_fragment          = m_is_fragment;
            seen.more_fragments       = m_more_fragments;
            seen.fragment_byte_offset = m_fragment_byte_offset;
            sb.check_verdict(seen);
            result_hold = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    always @(negedge aclk) begin
        if (result_hold > 0) begin
            m_ready = 1'b0;
            result_hold--;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d verdicts outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Valid stays high from one byte to the next unless a gap is drawn.
    task automatic send_byte(input logic [7:0] data, input logic last, input bit fast);
        int gap;
        gap = (fast || no_idle) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_byte = data;
        s_last_byte = last;
        do @(posedge aclk); while (!s_ready);
        sb.absorb_byte(data, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packet(input bit fast);
        foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, fast);
        packets_sent++;
    endtask

    // Drop valid, let every verdict drain, then give the block time to settle.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_enable(input logic value);
        cfg_valid         = 1'b1;
        cfg_input_enabled = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_enable(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic void compose_packet(input pkt_spec_t p);
        int          hdr_len;
        int          span;
        logic [7:0]  hdr[60];
        logic [16:0] acc;
        logic [15:0] sum16;
        logic [15:0] len16;
        hdr_len = p.ihl * 4;
        span    = (hdr_len < 20) ? 20 : hdr_len;
        for (int i = 0; i < span; i++) hdr[i] = 8'($urandom_range(0, 255));
        len16 = p.auto_len ? 16'(hdr_len + p.payload) : p.tot_len;
        hdr[0]  = {p.version, p.ihl};
        hdr[2]  = len16[15:8];
        hdr[3]  = len16[7:0];
        hdr[4]  = p.ident[15:8];
        hdr[5]  = p.ident[7:0];
        hdr[6]  = p.flags_off[15:8];
        hdr[7]  = p.flags_off[7:0];
        hdr[8]  = p.ttl;
        hdr[9]  = p.proto;
        hdr[10] = '0;
        hdr[11] = '0;
        for (int i = 0; i < 4; i++) begin
            hdr[12 + i] = p.src[31 - 8*i -: 8];
            hdr[16 + i] = p.dst[31 - 8*i -: 8];
        end
        sum16 = '0;
        for (int i = 0; i < hdr_len; i += 2) begin
            acc   = sum16 + {hdr[i], hdr[i + 1]};
            sum16 = acc[15:0] + acc[16];
        end
        sum16 = ~sum16;
        if (p.bad_cks) sum16 ^= 16'($urandom_range(1, 65535));
        hdr[10] = sum16[15:8];
        hdr[11] = sum16[7:0];
        pkt_bytes.delete();
        for (int i = 0; i < span; i++) pkt_bytes.push_back(hdr[i]);
        repeat (p.payload + p.extra) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        if (p.cut > 0)
            while (pkt_bytes.size() > p.cut) void'(pkt_bytes.pop_back());
    endfunction

    function automatic pkt_spec_t random_spec();
        pkt_spec_t s;
        s.version   = IP_VERSION;
        s.ihl       = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        s.auto_len  = 1'b1;
        s.tot_len   = '0;
        s.ident     = 16'($urandom);
        s.flags_off = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
        s.ttl       = 8'($urandom_range(1, 255));
        s.proto     = 8'($urandom);
        s.src       = $urandom;
        s.dst       = $urandom;
        s.payload   = $urandom_range(0, 12);
        s.extra     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        s.cut       = 0;
        s.bad_cks   = 1'b0;
        return s;
    endfunction

    task automatic run_packet(input pkt_spec_t p, input bit fast);
        compose_packet(p);
        send_packet(fast);
    endtask

    // Mostly well-formed headers; the rest break one check or are plain noise.
    task automatic random_packet();
        pkt_spec_t p;
        int        pick;
        int        n;
        p    = random_spec();
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 65) p.version = 4'($urandom);
        else if (pick >= 65 && pick < 70) p.ihl = 4'($urandom);
        else if (pick >= 70 && pick < 75) p.bad_cks = 1'b1;
        else if (pick >= 75 && pick < 80) begin
            p.auto_len = 1'b0;
            p.tot_len  = 16'($urandom_range(0, 80));
        end else if (pick >= 80 && pick < 85) p.ttl = '0;
        compose_packet(p);
        if (pick >= 85 && pick < 92) begin
            n = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
        end else if (pick >= 92 && pick < 97) begin
            n = $urandom_range(0, pkt_bytes.size() - 1);
            pkt_bytes[n] ^= 8'($urandom_range(1, 255));
        end else if (pick >= 97) begin
            pkt_bytes.delete();
            repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom));
        end
        no_idle = calm_phase || ($urandom_range(0, 5) == 0);
        send_packet(1'b0);
    endtask

    initial begin
        pkt_spec_t p;
        int        rand_bytes0;
        int        rand_pkts0;
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_input_enabled = 1'b1;
        s_valid           = 1'b0;
        s_data_byte       = '0;
        s_last_byte       = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        write_enable(1'b1);

        // zero ident, proto, addresses and flags, bare header
        p = random_spec();
        p.ihl = 4'd5; p.ident = '0; p.src = '0; p.dst = '0; p.proto = '0;
        p.ttl = 8'hff; p.flags_off = '0; p.payload = 0; p.extra = 0;
        run_packet(p, 1'b0);
        // all-ones ident, proto and addresses, full options, MF with the largest offset
        p = random_spec();
        p.ihl = 4'd15; p.ident = '1; p.src = '1; p.dst = '1; p.proto = '1;
        p.ttl = 8'd1; p.flags_off = FLAG_MF | OFFSET_MASK;
        run_packet(p, 1'b0);
        // don't-fragment only: not a fragment
        p = random_spec();
        p.flags_off = FLAG_DF;
        run_packet(p, 1'b0);
        // offset without MF: last fragment
        p = random_spec();
        p.flags_off = 16'h0001;
        run_packet(p, 1'b0);
        // trailing bytes past total length are ignored
        p = random_spec();
        p.extra = 7;
        run_packet(p, 1'b0);
        // single-byte and 19-byte packets
        p = random_spec();
        p.cut = 1;
        run_packet(p, 1'b0);
        p = random_spec();
        p.cut = 19;
        run_packet(p, 1'b0);
        p = random_spec();
        p.version = 4'd6;
        run_packet(p, 1'b0);
        // header length below minimum, then above packet length
        p = random_spec();
        p.ihl = 4'd4;
        run_packet(p, 1'b0);
        p = random_spec();
        p.ihl = 4'd15; p.payload = 0; p.cut = 40;
        run_packet(p, 1'b0);
        p = random_spec();
        p.bad_cks = 1'b1;
        run_packet(p, 1'b0);
        p = random_spec();
        p.auto_len = 1'b0; p.tot_len = '0;
        run_packet(p, 1'b0);
        p = random_spec();
        p.ihl = 4'd5; p.auto_len = 1'b0; p.payload = 4; p.extra = 0; p.tot_len = 16'd29;
        run_packet(p, 1'b0);
        p = random_spec();
        p.ttl = '0;
        run_packet(p, 1'b0);

        wait_idle();
        write_enable(1'b0);
        run_packet(random_spec(), 1'b0);
        p = random_spec();
        p.cut = 1;
        run_packet(p, 1'b0);
        wait_idle();
        write_enable(1'b1);

        rand_bytes0 = bytes_sent;
        rand_pkts0  = packets_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 2) write_enable(1'b0);
            else if (phase == 4) write_enable(1'($urandom_range(0, 1)));
            else write_enable(1'b1);
            calm_phase = (phase == 3);
            while (bytes_sent - rand_bytes0 < (phase + 1) * RANDOM_BYTES / PHASES ||
                   packets_sent - rand_pkts0 < (phase + 1) * RANDOM_PACKETS / PHASES)
                random_packet();
        end
        calm_phase = 1'b0;
        no_idle    = 1'b0;

        wait_idle();
        $display("Sent %0d bytes in %0d packets under both enable settings; %0d %s",
                 bytes_sent, packets_sent, sb.checked, "verdicts checked");
        $display("Verdict mix: ok %0d, disabled %0d, short %0d, version %0d, %s%0d, %s%0d,",
                 sb.verdict_tally[0], sb.verdict_tally[1], sb.verdict_tally[2],
                 sb.verdict_tally[3], "hdrlen ", sb.verdict_tally[4],
                 "checksum ", sb.verdict_tally[5]);
        $display("    totlen %0d, truncated %0d, ttl %0d",
                 sb.verdict_tally[6], sb.verdict_tally[7], sb.verdict_tally[8]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ihv_pkg.sv
rtl/ihv_fifo.sv
rtl/ihv_front.sv
rtl/ihv_back.sv
rtl/ipv4_header_validator.sv
sim/ipv4_header_validator_test.sv
